[rtl/tpsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types, register indexes, codes and color helpers of the TGA pixel
// stream decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_TOP   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_RIGHT = 3'd5;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	localparam logic STATUS_PIXEL  = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	localparam logic [7:0] COUNT_MASK = 8'h7F;
	localparam int unsigned RUN_BIT   = 7;

	// v * 255 / 31 by reciprocal: ceil(2^20 / 31), exact for 5-bit v
	localparam int unsigned SCALE_NUM   = 255;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP31     = (1 << RECIP_SHIFT) / 31 + 1;

	typedef enum logic [1:0] {
		FMT_GRAY8  = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_BGR24  = 2'd2,
		FMT_BGRA32 = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		fmt_t        fmt;
		logic        rle;
		logic        origin_top;
		logic        origin_right;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] col;
		logic [31:0] addr;
		logic        done;
	} pos_t;

	typedef struct packed {
		logic        status;
		logic [15:0] row;
		logic [15:0] col;
		logic [31:0] pixel_address;
		rgba_t       color;
		logic        image_done;
		logic        run_pending;
	} result_t;

	function automatic logic [7:0] scale5(input logic [4:0] v);
		logic [12:0] prod;
		logic [28:0] quot;
		prod = 13'(v) * 13'(SCALE_NUM);
		quot = 29'(prod) * 29'(RECIP31);
		return quot[RECIP_SHIFT +: 8];
	endfunction

endpackage
`default_nettype wire

[rtl/tpsd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpsd_if
// Valid/ready channels: stream bytes in, decoded pixels out.
// ----------------------------------------------------------------------------
interface tpsd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface tpsd_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [15:0] row;
	logic [15:0] col;
	logic [31:0] pixel_address;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        image_done;
	logic        run_pending;

	modport source (
		output valid, output status, output row, output col, output pixel_address,
		output red, output green, output blue, output alpha, output image_done,
		output run_pending, input ready
	);
	modport sink (
		input valid, input status, input row, input col, input pixel_address,
		input red, input green, input blue, input alpha, input image_done,
		input run_pending, output ready
	);
endinterface
`default_nettype wire

[rtl/tpsd_color.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpsd_color
// Converts assembled pixel bytes of the selected source format to RGBA.
// ----------------------------------------------------------------------------
module tpsd_color import tpsd_pkg::*; (
	input  fmt_t            fmt,
	input  logic [3:0][7:0] pix,
	output rgba_t           color
);

	logic [15:0] word;

	assign word = {pix[1], pix[0]};

	always_comb begin
		unique case (fmt)
			FMT_GRAY8: begin
				color = '{red: pix[0], green: pix[0], blue: pix[0], alpha: 8'hFF};
			end
			FMT_RGB555: begin
				color = '{red: scale5(word[14:10]), green: scale5(word[9:5]),
					blue: scale5(word[4:0]), alpha: 8'hFF};
			end
			FMT_BGR24: begin
				color = '{red: pix[2], green: pix[1], blue: pix[0], alpha: 8'hFF};
			end
			FMT_BGRA32: begin
				color = '{red: pix[2], green: pix[1], blue: pix[0], alpha: pix[3]};
			end
			default: begin
				color = '{red: pix[0], green: pix[0], blue: pix[0], alpha: 8'hFF};
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/tpsd_position.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpsd_position
// Row, column and pixel counters with origin flip, address and image end.
// ----------------------------------------------------------------------------
module tpsd_position import tpsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	output pos_t pos
);

	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [31:0] count_q;
	logic [31:0] total;
	logic [15:0] col_inc;
	logic [31:0] count_inc;
	logic [15:0] row_flip;
	logic [15:0] col_flip;

	assign row_flip  = cfg.origin_top ? row_q : 16'(cfg.height - 16'd1 - row_q);
	assign col_flip  = cfg.origin_right ? 16'(cfg.width - 16'd1 - col_q) : col_q;
	assign col_inc   = 16'(col_q + 16'd1);
	assign count_inc = 32'(count_q + 32'd1);
	assign total     = 32'(cfg.width) * 32'(cfg.height);

	assign pos.row  = row_flip;
	assign pos.col  = col_flip;
	assign pos.addr = 32'(32'(row_flip) * 32'(cfg.width) + 32'(col_flip));
	assign pos.done = (count_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			count_q <= '0;
		end else begin
			if (step) begin
				if (pos.done) begin
					row_q   <= '0;
					col_q   <= '0;
					count_q <= '0;
				end else begin
					count_q <= count_inc;
					if (col_inc >= cfg.width) begin
						col_q <= '0;
						row_q <= 16'(row_q + 16'd1);
					end else begin
						col_q <= col_inc;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/tga_pixel_stream_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit
// Decodes raw or RLE coded TGA pixel bytes into positioned RGBA pixels.
// ----------------------------------------------------------------------------
// Each accepted beat that yields a result is registered straight into the output register.
// Throughput: one beat per cycle; the output register stalls input only while
// a result is held and the sink is not ready.
// Reset: arst_n clears packet state, counters and output valid, and loads the
// configuration defaults (1x1 image, gray8, raw, bottom-left origin).
module tga_pixel_stream_decoder_unit import tpsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tpsd_in_if.sink                stream,
	tpsd_out_if.source             pixels
);

	cfg_t        cfg_q;
	logic        await_q, await_n;
	logic        is_run_q, is_run_n;
	logic        loaded_q, loaded_n;
	logic [7:0]  left_q, left_n;
	logic [1:0]  slot_q, slot_n;
	logic [7:0]  store_q [3];
	rgba_t       run_color_q, run_color_n;
	result_t     res_q;
	logic        res_valid_q;

	logic            accept;
	logic            emit;
	logic            reject;
	logic            store_we;
	logic [7:0]      left_dec;
	logic [3:0][7:0] pix;
	rgba_t           decoded;
	rgba_t           color_sel;
	pos_t            pos;

	assign accept       = stream.valid && stream.ready;
	assign stream.ready = !res_valid_q || pixels.ready;
	assign left_dec     = 8'(left_q - 8'd1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (slot_q == 2'(i)) begin
				pix[i] = stream.data_byte;
			end else begin
				pix[i] = store_q[i];
			end
		end
		pix[3] = stream.data_byte;
	end

	tpsd_color u_color (
		.fmt   (cfg_q.fmt),
		.pix   (pix),
		.color (decoded)
	);

	tpsd_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (emit),
		.pos    (pos)
	);

	always_comb begin
		await_n     = await_q;
		is_run_n    = is_run_q;
		loaded_n    = loaded_q;
		left_n      = left_q;
		slot_n      = slot_q;
		run_color_n = run_color_q;
		emit        = 1'b0;
		reject      = 1'b0;
		store_we    = 1'b0;
		color_sel   = run_color_q;
		if (accept) begin
			priority if (stream.kind == KIND_DRAIN) begin
				if (loaded_q) begin
					left_n = left_dec;
					if (left_dec == 8'd0) begin
						loaded_n = 1'b0;
						await_n  = 1'b1;
					end
					emit = 1'b1;
				end
			end else if (loaded_q) begin
				reject = 1'b1;
			end else if (cfg_q.rle && await_q) begin
				left_n   = 8'((stream.data_byte & COUNT_MASK) + 8'd1);
				is_run_n = stream.data_byte[RUN_BIT];
				await_n  = 1'b0;
				slot_n   = '0;
			end else begin
				store_we = 1'b1;
				if (slot_q < 2'(cfg_q.fmt)) begin
					slot_n = 2'(slot_q + 2'd1);
				end else begin
					slot_n    = '0;
					color_sel = decoded;
					emit      = 1'b1;
					if (cfg_q.rle) begin
						left_n = left_dec;
						if (left_dec == 8'd0) begin
							await_n = 1'b1;
						end else if (is_run_q) begin
							run_color_n = decoded;
							loaded_n    = 1'b1;
						end
					end
				end
			end
			if (emit && pos.done) begin
				await_n  = 1'b1;
				is_run_n = 1'b0;
				loaded_n = 1'b0;
				left_n   = '0;
				slot_n   = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we && slot_q != 2'd3) begin
			store_q[slot_q] <= stream.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '{width: 16'd1, height: 16'd1, fmt: FMT_GRAY8, rle: 1'b0,
				origin_top: 1'b0, origin_right: 1'b0};
			await_q     <= 1'b1;
			is_run_q    <= 1'b0;
			loaded_q    <= 1'b0;
			left_q      <= '0;
			slot_q      <= '0;
			run_color_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  cfg_q.width        <= cfg_data;
					REG_IMAGE_HEIGHT: cfg_q.height       <= cfg_data;
					REG_PIXEL_FORMAT: cfg_q.fmt          <= fmt_t'(cfg_data[1:0]);
					REG_RLE_ENABLE:   cfg_q.rle          <= cfg_data[0];
					REG_ORIGIN_TOP:   cfg_q.origin_top   <= cfg_data[0];
					REG_ORIGIN_RIGHT: cfg_q.origin_right <= cfg_data[0];
					default: begin
					end
				endcase
			end
			await_q     <= await_n;
			is_run_q    <= is_run_n;
			loaded_q    <= loaded_n;
			left_q      <= left_n;
			slot_q      <= slot_n;
			run_color_q <= run_color_n;
			if (emit || reject) begin
				res_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= '{status: STATUS_PIXEL, row: pos.row, col: pos.col,
				pixel_address: pos.addr, color: color_sel, image_done: pos.done,
				run_pending: loaded_n};
		end else if (reject) begin
			res_q <= '{status: STATUS_REJECT, row: '0, col: '0, pixel_address: '0,
				color: '0, image_done: 1'b0, run_pending: 1'b1};
		end
	end

	assign pixels.valid         = res_valid_q;
	assign pixels.status        = res_q.status;
	assign pixels.row           = res_q.row;
	assign pixels.col           = res_q.col;
	assign pixels.pixel_address = res_q.pixel_address;
	assign pixels.red           = res_q.color.red;
	assign pixels.green         = res_q.color.green;
	assign pixels.blue          = res_q.color.blue;
	assign pixels.alpha         = res_q.color.alpha;
	assign pixels.image_done    = res_q.image_done;
	assign pixels.run_pending   = res_q.run_pending;

endmodule
`default_nettype wire

[tb/tga_pixel_stream_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit_tb
// Drives raw and RLE coded pixel bytes and drain beats into the decoder under
// a series of image setups and flow-control patterns. A directed table comes
// first, then random packet streams. Every result beat is compared field by
// field against a typed row or a behavioral model in step with accepted input.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit_tb;
	import tpsd_pkg::*;

	localparam int SETTLE      = 4;
	localparam int END_PAD     = 8;
	localparam int WATCHDOG    = 1000;
	localparam int PHASES      = 16;
	localparam int PHASE_BEATS = 35;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_TYPED, ROW_CFG} want_t;

	typedef struct {
		want_t      what;
		logic       k;
		logic [7:0] b;
		result_t    res;
		cfg_t       cfg;
	} probe_t;

	localparam result_t NO_RESULT = '0;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic sink_ready = 1'b0;

	tpsd_in_if  byte_ch ();
	tpsd_out_if pixel_ch ();

	assign pixel_ch.ready = sink_ready;

	tga_pixel_stream_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stream    (byte_ch),
		.pixels    (pixel_ch)
	);

	// decoder state as seen from outside
	cfg_t       model_cfg = '{16'd1, 16'd1, FMT_GRAY8, 1'b0, 1'b0, 1'b0};
	logic       hdr_wait  = 1'b1;
	logic [7:0] pkt_left  = '0;
	logic       pkt_run   = 1'b0;
	logic [1:0] slot      = '0;
	logic [7:0] pix_bytes [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
	rgba_t      rep_color = '0;
	logic       rep_live  = 1'b0;
	logic [31:0] px_count = '0;
	logic [15:0] row_cnt  = '0;
	logic [15:0] col_cnt  = '0;

	result_t expected_pixels [$];
	probe_t  probes [$];
	want_t   tag_want;
	result_t tag_res;
	int      idle_pct  = 0;
	int      stall_pct = 0;
	int      live_beats = 0;
	int      mismatches = 0;
	int      quiet = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		sink_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	function automatic rgba_t unpack_color();
		rgba_t c;
		logic [15:0] v;
		v = {pix_bytes[1], pix_bytes[0]};
		c.alpha = 8'hFF;
		case (model_cfg.fmt)
			FMT_GRAY8: begin
				c.red = pix_bytes[0];
				c.green = pix_bytes[0];
				c.blue = pix_bytes[0];
			end
			FMT_RGB555: begin
				c.red = 8'((32'(v[14:10]) * 255) / 31);
				c.green = 8'((32'(v[9:5]) * 255) / 31);
				c.blue = 8'((32'(v[4:0]) * 255) / 31);
			end
			default: begin
				c.red = pix_bytes[2];
				c.green = pix_bytes[1];
				c.blue = pix_bytes[0];
				if (model_cfg.fmt == FMT_BGRA32)
					c.alpha = pix_bytes[3];
			end
		endcase
		return c;
	endfunction

	function automatic result_t place_pixel(input rgba_t c);
		result_t res;
		logic [31:0] total;
		res = '0;
		res.status = STATUS_PIXEL;
		res.row = model_cfg.origin_top ? row_cnt : model_cfg.height - 16'd1 - row_cnt;
		res.col = model_cfg.origin_right ? model_cfg.width - 16'd1 - col_cnt : col_cnt;
		res.pixel_address = 32'(res.row) * 32'(model_cfg.width) + 32'(res.col);
		res.color = c;
		total = 32'(model_cfg.width) * 32'(model_cfg.height);
		col_cnt = col_cnt + 16'd1;
		if (col_cnt >= model_cfg.width) begin
			col_cnt = '0;
			row_cnt = row_cnt + 16'd1;
		end
		px_count = px_count + 32'd1;
		res.image_done = (px_count >= total);
		if (res.image_done) begin
			px_count = '0;
			row_cnt = '0;
			col_cnt = '0;
			hdr_wait = 1'b1;
			pkt_left = '0;
			pkt_run = 1'b0;
			rep_live = 1'b0;
			slot = '0;
		end
		res.run_pending = rep_live;
		return res;
	endfunction

	function automatic bit decode_beat(input logic k, input logic [7:0] b, output result_t res);
		rgba_t c;
		res = '0;
		if (k == KIND_DRAIN) begin
			if (!rep_live)
				return 1'b0;
			pkt_left = pkt_left - 8'd1;
			if (pkt_left == 8'd0) begin
				rep_live = 1'b0;
				hdr_wait = 1'b1;
			end
			res = place_pixel(rep_color);
			return 1'b1;
		end
		if (rep_live) begin
			res.status = STATUS_REJECT;
			res.run_pending = 1'b1;
			return 1'b1;
		end
		if (model_cfg.rle && hdr_wait) begin
			pkt_left = (b & COUNT_MASK) + 8'd1;
			pkt_run = b[RUN_BIT];
			hdr_wait = 1'b0;
			slot = '0;
			return 1'b0;
		end
		pix_bytes[slot] = b;
		if (int'(slot) + 1 < int'(model_cfg.fmt) + 1) begin
			slot = slot + 2'd1;
			return 1'b0;
		end
		slot = '0;
		c = unpack_color();
		if (model_cfg.rle) begin
			pkt_left = pkt_left - 8'd1;
			if (pkt_left == 8'd0) begin
				hdr_wait = 1'b1;
			end else if (pkt_run) begin
				rep_color = c;
				rep_live = 1'b1;
			end
		end
		res = place_pixel(c);
		return 1'b1;
	endfunction

	task automatic diff(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		result_t calc;
		bit made;
		bit active;
		active = 1'b0;
		if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
			active = 1'b1;
			made = decode_beat(byte_ch.kind, byte_ch.data_byte, calc);
			if (made || byte_ch.kind == KIND_DATA)
				live_beats++;
			case (tag_want)
				ROW_TYPED: expected_pixels.push_back(tag_res);
				ROW_NONE: ;
				default: if (made) expected_pixels.push_back(calc);
			endcase
		end
		if (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
			active = 1'b1;
			got.status = pixel_ch.status;
			got.row = pixel_ch.row;
			got.col = pixel_ch.col;
			got.pixel_address = pixel_ch.pixel_address;
			got.color = '{pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha};
			got.image_done = pixel_ch.image_done;
			got.run_pending = pixel_ch.run_pending;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat expected none actual %0h", $time, got);
			end else begin
				want = expected_pixels.pop_front();
				diff("status", 32'(want.status), 32'(got.status));
				diff("row", 32'(want.row), 32'(got.row));
				diff("col", 32'(want.col), 32'(got.col));
				diff("pixel_address", want.pixel_address, got.pixel_address);
				diff("red", 32'(want.color.red), 32'(got.color.red));
				diff("green", 32'(want.color.green), 32'(got.color.green));
				diff("blue", 32'(want.color.blue), 32'(got.color.blue));
				diff("alpha", 32'(want.color.alpha), 32'(got.color.alpha));
				diff("image_done", 32'(want.image_done), 32'(got.image_done));
				diff("run_pending", 32'(want.run_pending), 32'(got.run_pending));
			end
		end
		quiet = active ? 0 : quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_beat(input logic k, input logic [7:0] b,
			input want_t w = ROW_PREDICT, input result_t r = '0);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.kind <= k;
		byte_ch.data_byte <= b;
		tag_want <= w;
		tag_res <= r;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
	endtask

	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_setup(input cfg_t c);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= c.width;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= c.height;
		@(posedge clk);
		cfg_index <= REG_PIXEL_FORMAT;
		cfg_data <= CFG_DATA_W'(c.fmt);
		@(posedge clk);
		cfg_index <= REG_RLE_ENABLE;
		cfg_data <= CFG_DATA_W'(c.rle);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_TOP;
		cfg_data <= CFG_DATA_W'(c.origin_top);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_RIGHT;
		cfg_data <= CFG_DATA_W'(c.origin_right);
		@(posedge clk);
		cfg_write <= 1'b0;
		model_cfg = c;
	endtask

	function automatic void add_row(input want_t what, input logic k, input logic [7:0] b,
			input result_t res = '0, input cfg_t c = '0);
		probe_t p;
		p.what = what;
		p.k = k;
		p.b = b;
		p.res = res;
		p.cfg = c;
		probes.push_back(p);
	endfunction

	function automatic cfg_t pick_setup(input int p);
		cfg_t c;
		c.width = 16'($urandom_range(1, 6));
		c.height = 16'($urandom_range(1, 4));
		c.fmt = fmt_t'($urandom_range(3));
		c.rle = ($urandom_range(3) != 0);
		c.origin_top = 1'($urandom);
		c.origin_right = 1'($urandom);
		case (p)
			0: c = '{16'd1, 16'd1, FMT_GRAY8, 1'b0, 1'b0, 1'b0};
			1: c = '{16'hFFFF, 16'hFFFF, FMT_BGRA32, 1'b1, 1'b1, 1'b1};
			2: c = '{16'd0, 16'd3, FMT_RGB555, 1'b1, 1'b0, 1'b1};
			3: c = '{16'd5, 16'd0, FMT_BGR24, 1'b1, 1'b1, 1'b0};
			4: c = '{16'hFFFF, 16'd1, FMT_GRAY8, 1'b0, 1'b0, 1'b1};
			5: c = '{16'd1, 16'hFFFF, FMT_RGB555, 1'b0, 1'b1, 1'b0};
			default: ;
		endcase
		return c;
	endfunction

	task automatic gen_chunk();
		int bpp;
		int cnt;
		logic run;
		bpp = int'(model_cfg.fmt) + 1;
		if (!model_cfg.rle) begin
			if ($urandom_range(11) == 0)
				send_beat(KIND_DRAIN, 8'($urandom));
			else
				send_beat(KIND_DATA, 8'($urandom));
		end else if ($urandom_range(9) == 0) begin
			send_beat(1'($urandom), 8'($urandom));
		end else begin
			run = 1'($urandom);
			cnt = (run && $urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(5);
			send_beat(KIND_DATA, {run, 7'(cnt)});
			if (run) begin
				repeat (bpp) send_beat(KIND_DATA, 8'($urandom));
				repeat (cnt) begin
					if ($urandom_range(11) == 0)
						send_beat(KIND_DATA, 8'($urandom));
					send_beat(KIND_DRAIN, 8'($urandom));
				end
			end else begin
				repeat ((cnt + 1) * bpp) send_beat(KIND_DATA, 8'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int base;
		bit paused;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.kind <= KIND_DATA;
		byte_ch.data_byte <= 8'h00;
		tag_want <= ROW_PREDICT;
		tag_res <= NO_RESULT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		add_row(ROW_TYPED, KIND_DATA, 8'h00, result_t'{STATUS_PIXEL, 16'd0, 16'd0, 32'd0,
			rgba_t'{8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, 1'b0});
		add_row(ROW_TYPED, KIND_DATA, 8'hFF, result_t'{STATUS_PIXEL, 16'd0, 16'd0, 32'd0,
			rgba_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0});
		add_row(ROW_NONE, KIND_DRAIN, 8'h00);
		add_row(ROW_CFG, KIND_DATA, 8'h00, NO_RESULT,
			cfg_t'{16'd3, 16'd2, FMT_RGB555, 1'b1, 1'b1, 1'b0});
		add_row(ROW_PREDICT, KIND_DATA, 8'h81);
		add_row(ROW_PREDICT, KIND_DATA, 8'hFF);
		add_row(ROW_PREDICT, KIND_DATA, 8'h7F);
		add_row(ROW_TYPED, KIND_DATA, 8'h12, result_t'{STATUS_REJECT, 16'd0, 16'd0, 32'd0,
			rgba_t'{8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b1});
		add_row(ROW_PREDICT, KIND_DRAIN, 8'h00);
		add_row(ROW_NONE, KIND_DRAIN, 8'hFF);
		add_row(ROW_PREDICT, KIND_DATA, 8'h00);
		add_row(ROW_PREDICT, KIND_DATA, 8'h00);
		add_row(ROW_PREDICT, KIND_DATA, 8'h00);
		add_row(ROW_PREDICT, KIND_DATA, 8'h02);
		add_row(ROW_PREDICT, KIND_DATA, 8'h1F);
		add_row(ROW_PREDICT, KIND_DATA, 8'h00);
		add_row(ROW_PREDICT, KIND_DATA, 8'hE0);
		add_row(ROW_PREDICT, KIND_DATA, 8'h03);
		add_row(ROW_PREDICT, KIND_DATA, 8'h00);
		add_row(ROW_PREDICT, KIND_DATA, 8'hFC);
		add_row(ROW_CFG, KIND_DATA, 8'h00, NO_RESULT,
			cfg_t'{16'd2, 16'd1, FMT_BGRA32, 1'b0, 1'b0, 1'b1});
		add_row(ROW_PREDICT, KIND_DATA, 8'h01);
		add_row(ROW_PREDICT, KIND_DATA, 8'h02);
		add_row(ROW_PREDICT, KIND_DATA, 8'h03);
		add_row(ROW_PREDICT, KIND_DATA, 8'h04);

		foreach (probes[i]) begin
			if (probes[i].what == ROW_CFG)
				apply_setup(probes[i].cfg);
			else
				send_beat(probes[i].k, probes[i].b, probes[i].what, probes[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			apply_setup(pick_setup(p));
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct = 28;
					stall_pct = 28;
				end
			endcase
			base = live_beats;
			paused = 1'b0;
			while (live_beats - base < PHASE_BEATS) begin
				gen_chunk();
				// hold off until the decoder has delivered everything
				if (!paused && live_beats - base >= PHASE_BEATS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
		end

		wait_idle();
		repeat (END_PAD) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[tga_pixel_stream_decoder_unit.f]
rtl/tpsd_pkg.sv
rtl/tpsd_if.sv
rtl/tpsd_color.sv
rtl/tpsd_position.sv
rtl/tga_pixel_stream_decoder_unit.sv
tb/tga_pixel_stream_decoder_unit_tb.sv
